### sv/psv_pkg.sv
// shared types, constants and helpers for the saw voice engine
`default_nettype none
package psv_pkg;

  localparam int unsigned VoicesDefault = 12;
  localparam int unsigned LevelW        = 21;
  localparam int unsigned StepW         = 32;
  localparam int unsigned SumW          = 32;
  localparam logic [LevelW-1:0] LevelOne = 21'd1048576;

  localparam logic [LevelW-1:0] AttackRst  = 21'd1049;
  localparam logic [LevelW-1:0] DecayRst   = 21'd1049;
  localparam logic [LevelW-1:0] SustainRst = 21'd629146;
  localparam logic [LevelW-1:0] ReleaseRst = 21'd52;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MIX,
    ST_OUT
  } state_t;

  // envelope registers handed to the voice unit
  typedef struct packed {
    logic [LevelW-1:0] attack;
    logic [LevelW-1:0] decay;
    logic [LevelW-1:0] sustain;
    logic [LevelW-1:0] rel_step;
  } env_cfg_t;

  function automatic logic [StepW-1:0] base_step(input logic [3:0] note);
    logic [StepW-1:0] s;
    case (note)
      4'd0:    s = 32'd51076056;
      4'd1:    s = 32'd54113197;
      4'd2:    s = 32'd57330935;
      4'd3:    s = 32'd60740009;
      4'd4:    s = 32'd64351798;
      4'd5:    s = 32'd68178356;
      4'd6:    s = 32'd72232452;
      4'd7:    s = 32'd76527617;
      4'd8:    s = 32'd81078186;
      4'd9:    s = 32'd85899345;
      4'd10:   s = 32'd91007186;
      4'd11:   s = 32'd96418755;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [StepW-1:0] tuning(input logic [3:0] note,
                                              input logic [3:0] octave);
    logic [StepW-1:0] s;
    s = base_step(note);
    if (octave > 4'd4) s = s << (octave - 4'd4);
    else if (octave < 4'd4) s = s >> (4'd4 - octave);
    return s;
  endfunction

endpackage
`default_nettype wire

### sv/psv_env_unit.sv
// shared envelope and phase unit, one voice per cycle
`default_nettype none
module psv_env_unit
  import psv_pkg::*;
(
  input  wire env_cfg_t          cfg,
  input  wire logic              held,
  input  wire logic              released,
  input  wire logic [LevelW-1:0] level_in,
  input  wire logic [StepW-1:0]  phase_in,
  input  wire logic [StepW-1:0]  step_in,
  output logic                   freed,
  output logic [LevelW-1:0]      level_out,
  output logic [StepW-1:0]       phase_out,
  output logic signed [9:0]      raw_out,
  output logic [7:0]             mag_out
);
  logic [LevelW:0] sum_att;
  logic [LevelW-1:0] lvl;

  always_comb begin
    lvl     = level_in;
    freed   = 1'b0;
    sum_att = {1'b0, level_in} + {1'b0, cfg.attack};
    if (held) begin
      if (level_in < LevelOne) begin
        lvl = (sum_att > {1'b0, LevelOne}) ? LevelOne : sum_att[LevelW-1:0];
      end else if (level_in > cfg.sustain) begin
        lvl = (cfg.decay >= level_in - cfg.sustain) ? cfg.sustain
                                                    : level_in - cfg.decay;
      end
    end else if (released && level_in != '0) begin
      if (cfg.rel_step >= level_in) begin
        freed = 1'b1;
        lvl   = '0;
      end else begin
        lvl = level_in - cfg.rel_step;
      end
    end
    level_out = lvl;
    phase_out = (!freed && lvl != '0) ? phase_in + step_in : phase_in;
    raw_out   = $signed({2'b00, phase_out[31:24]}) - 10'sd128;
    mag_out   = raw_out[9] ? 8'(-raw_out) : raw_out[7:0];
  end
endmodule
`default_nettype wire

### sv/psv_mix_acc.sv
// mix accumulator: registered product, signed sum, shift and clip
`default_nettype none
module psv_mix_acc
  import psv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              clear,
  input  wire logic              add_en,
  input  wire logic              neg,
  input  wire logic [7:0]        mag,
  input  wire logic [LevelW-1:0] level,
  input  wire logic [3:0]        volume,
  output logic [7:0]             sample
);
  logic [28:0] prod_r, prod_nxt;
  logic        neg_r, vld_r;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic signed [SumW-1:0] part, shifted;
  logic [3:0] sh;

  always_comb begin
    prod_nxt = {13'd0, mag} * {8'd0, level};
    part     = $signed({{(SumW-9){1'b0}}, prod_r[28:20]});
    sum_nxt  = sum_r;
    if (clear) sum_nxt = '0;
    else if (vld_r) sum_nxt = neg_r ? sum_r - part : sum_r + part;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= neg;
    vld_r  <= add_en;
    sum_r  <= sum_nxt;
  end

  always_comb begin
    sh      = (volume > 4'd8) ? 4'd0 : 4'd8 - volume;
    shifted = sum_r >>> sh;
    if (shifted > 32'sd127) sample = 8'd255;
    else if (shifted < -32'sd128) sample = 8'd0;
    else sample = 8'(shifted + 32'sd128);
  end
endmodule
`default_nettype wire

### sv/polyphonic_saw_voice_engine_unit.sv
// top level: voice table, sequencer, shared envelope unit and mixer
//
//   channel | ports                              | notes
//   in      | in_valid/in_ready, kind..volume    | one beat per event
//   out     | out_valid/out_ready, out_sample    | one beat per tick
//   cfg     | cfg_we, cfg_index, cfg_data        | write only, no wait
//
// press and release: the idle state takes the beat, then VOICES+1 walk steps
// follow (the last one commits a press)
// a tick walks all voices through the shared envelope unit, one a cycle, then
// the mix state lets the product register settle into the sum and the out state
// loads the output register once the old sample is taken
// the output register lets the next beat in while a sample waits
// reset clears the voice flags and loads the envelope register defaults
`default_nettype none
module polyphonic_saw_voice_engine_unit
  import psv_pkg::*;
#(
  parameter int unsigned VOICES = VoicesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [3:0]  in_note,
  input  wire logic [3:0]  in_octave,
  input  wire logic [3:0]  in_volume,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_sample,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data
);
  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);

  // voice table
  logic [VOICES-1:0] active_r, held_r, rel_r;
  logic [3:0]        note_r   [VOICES];
  logic [3:0]        oct_r    [VOICES];
  logic [StepW-1:0]  step_r   [VOICES];
  logic [StepW-1:0]  phase_r  [VOICES];
  logic [LevelW-1:0] level_r  [VOICES];

  env_cfg_t cfg_r;
  state_t   state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0] drain_r, drain_nxt;
  kind_t      kind_r;
  logic [3:0] note_q_r, oct_q_r, vol_r;
  // search results of the press and release walks
  logic       hit_r, free_found_r;
  logic [VW-1:0] hit_idx_r, free_idx_r;
  logic       out_valid_r;
  logic [7:0] out_sample_r;

  wire [VW-1:0] vi = idx_r[VW-1:0];
  wire in_fire  = in_valid && in_ready;
  wire walking  = (state_r == ST_SCAN) && (idx_r < CW'(VOICES));
  wire match    = active_r[vi] && note_r[vi] == note_q_r && oct_r[vi] == oct_q_r;

  logic              e_freed;
  logic [LevelW-1:0] e_level;
  logic [StepW-1:0]  e_phase;
  logic signed [9:0] e_raw;
  logic [7:0]        e_mag;
  logic [7:0]        mix_sample;

  psv_env_unit u_env (
    .cfg(cfg_r), .held(held_r[vi]), .released(rel_r[vi]),
    .level_in(level_r[vi]), .phase_in(phase_r[vi]), .step_in(step_r[vi]),
    .freed(e_freed), .level_out(e_level), .phase_out(e_phase),
    .raw_out(e_raw), .mag_out(e_mag)
  );

  wire tick_use = walking && kind_r == KIND_TICK && active_r[vi] && !e_freed;

  psv_mix_acc u_mix (
    .clk(clk), .clear(in_fire), .add_en(tick_use), .neg(e_raw[9]),
    .mag(e_mag), .level(e_level), .volume(vol_r), .sample(mix_sample)
  );

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) begin
        state_nxt = (kind_t'(in_kind) == KIND_NONE) ? ST_IDLE : ST_SCAN;
        idx_nxt   = '0;
      end
      ST_SCAN: begin
        if (idx_r < CW'(VOICES)) idx_nxt = idx_r + 1'b1;
        else if (kind_r == KIND_TICK) begin
          state_nxt = ST_MIX;
          drain_nxt = '0;
        end else state_nxt = ST_IDLE;
      end
      ST_MIX: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == 2'd1) state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      drain_r      <= '0;
      out_valid_r  <= 1'b0;
      active_r     <= '0;
      held_r       <= '0;
      rel_r        <= '0;
      cfg_r        <= '{AttackRst, DecayRst, SustainRst, ReleaseRst};
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        note_r[i]  <= '0;
        oct_r[i]   <= '0;
        step_r[i]  <= '0;
        phase_r[i] <= '0;
        level_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      drain_r <= drain_nxt;
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= mix_sample;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ATTACK:  cfg_r.attack   <= cfg_data;
          REG_DECAY:   cfg_r.decay    <= cfg_data;
          REG_SUSTAIN: cfg_r.sustain  <= cfg_data;
          REG_RELEASE: cfg_r.rel_step <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        kind_r       <= kind_t'(in_kind);
        note_q_r     <= in_note;
        oct_q_r      <= in_octave;
        vol_r        <= in_volume;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
        hit_idx_r    <= '0;
        free_idx_r   <= '0;
      end
      if (walking) begin
        case (kind_r)
          KIND_TICK: if (active_r[vi]) begin
            level_r[vi] <= e_level;
            phase_r[vi] <= e_phase;
            if (e_freed) active_r[vi] <= 1'b0;
          end
          KIND_PRESS: begin
            if (match && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= vi;
            end
            if (!active_r[vi] && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= vi;
            end
          end
          KIND_RELEASE: if (match && held_r[vi] && !hit_r) begin
            hit_r      <= 1'b1;
            held_r[vi] <= 1'b0;
            rel_r[vi]  <= 1'b1;
          end
          default: ;
        endcase
      end
      // press commit after the walk
      if (state_r == ST_SCAN && idx_r == CW'(VOICES) && kind_r == KIND_PRESS
          && note_q_r <= 4'd11) begin
        if (hit_r) begin
          held_r[hit_idx_r]  <= 1'b1;
          rel_r[hit_idx_r]   <= 1'b0;
          level_r[hit_idx_r] <= '0;
          phase_r[hit_idx_r] <= '0;
        end else begin
          active_r[free_idx_r] <= 1'b1;
          held_r[free_idx_r]   <= 1'b1;
          rel_r[free_idx_r]    <= 1'b0;
          note_r[free_idx_r]   <= note_q_r;
          oct_r[free_idx_r]    <= oct_q_r;
          step_r[free_idx_r]   <= tuning(note_q_r, oct_q_r);
          level_r[free_idx_r]  <= '0;
          phase_r[free_idx_r]  <= '0;
        end
      end
    end
  end

  // a finished result is never overwritten before it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("sample dropped");
  // no beat is taken while the walk runs
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !in_ready)
    else $error("ready during walk");
  // the walk index never passes the table end
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CW'(VOICES))
    else $error("index overrun");
endmodule
`default_nettype wire
